// ===== design/nsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nsqrt_pkg
// Shared types and constants for the Newton square root block.
// ----------------------------------------------------------------------------
package nsqrt_pkg;

  // Field widths fixed by the stream format
  localparam int RADICAND_W  = 32;
  localparam int ROOT_W      = 52;
  localparam int STEPS_W     = 7;
  localparam int TOL_W       = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;   // root + steps_used, padded to whole bytes
  localparam int OUT_TUSER_W = 1;

  // Parameter defaults
  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 32;

  // Tolerance after reset, Q0.32, about 0.0001
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd429497;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_ERR,
    ST_CHK,
    ST_OUT
  } nsqrt_state_t;

endpackage

// ===== design/newton_square_root.sv =====
// ----------------------------------------------------------------------------
// newton_square_root
// Newton-Raphson square root of an unsigned Q20.12 value, iterating
// y = (x/y + y)/2 from the root of the previous request until |x - y*y|
// drops below the tolerance register or the step cap is reached.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in_     | in        | in_tvalid / in_tready   | tdata: radicand[31:0]
//  out_    | out       | out_tvalid / out_tready | tdata: root, steps_used;
//          |           |                         | tuser: converged
//  cfg_    | in        | cfg_valid / cfg_ready   | tolerance[31:0]
//
//  Each Newton step runs the restoring divider at one quotient bit per
//  cycle, then the estimate update, the squaring on the shared 32x32
//  multiplier (ST_SQ0 to ST_SQ3) and the error check (ST_ERR, ST_CHK). A
//  request runs steps_used steps, then loads the output register in ST_OUT.
//  in_tready is high only while the sequencer is idle, so a new request is
//  taken only after the previous one has finished all its steps.
//  The finished result sits in the output register while the next request
//  is taken; the sequencer waits at the end of a request only if the
//  previous result has not been taken yet. Reset is synchronous, active low.
//
module newton_square_root #(
  parameter int MAX_STEPS = nsqrt_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = nsqrt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // radicand[31:0]
  input  logic [nsqrt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // root[51:0], steps_used[58:52], zero pad[63:59]
  output logic [nsqrt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // converged[0]
  output logic [nsqrt_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tolerance[31:0]
  input  logic [nsqrt_pkg::TOL_W-1:0]        cfg_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready
);
  import nsqrt_pkg::*;

  localparam int EST_W     = 20 + FRAC_BITS;          // estimate, Q20.FRAC_BITS
  localparam int QUO_W     = EST_W + 1;               // saturated quotient
  localparam int DIV_SHIFT = 2 * FRAC_BITS - 12;
  localparam int DIV_BITS  = RADICAND_W + DIV_SHIFT;  // divider iterations
  localparam int CNT_W     = $clog2(DIV_BITS);
  localparam int ACC_W     = 2 * EST_W;               // full square
  localparam int SQ_SHIFT  = 2 * FRAC_BITS - 32;
  localparam int OVF_W     = ACC_W - SQ_SHIFT - 64;
  localparam int WIDE_W    = (EST_W > ROOT_W) ? EST_W : ROOT_W;

  nsqrt_state_t state_r, state_nxt;

  logic [TOL_W-1:0]      tol_r, tol_nxt;
  logic [EST_W-1:0]      est_r, est_nxt;
  logic [RADICAND_W-1:0] x_r, x_nxt;
  logic [STEPS_W-1:0]    steps_r, steps_nxt;
  logic [RADICAND_W-1:0] xsh_r, xsh_nxt;
  logic [EST_W:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic                  sat_r, sat_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [63:0]           err_r, err_nxt;
  logic                  fits_r, fits_nxt;
  logic                  conv_r, conv_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic                  ouser_r, ouser_nxt;
  logic                  ovalid_r, ovalid_nxt;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Divider step
  logic [EST_W:0]  rem_shift;
  logic [EST_W:0]  div_den;
  logic            quo_bit;

  // Estimate update
  logic [QUO_W-1:0] quo_fin;
  logic [EST_W+1:0] est_sum;
  logic [EST_W:0]   est_half;

  // Error check
  logic [63:0]     sq_q32;
  logic [63:0]     xq;
  logic [WIDE_W-1:0] est_wide;
  logic [STEPS_W-1:0] steps_inc;
  logic            conv_now;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // Pick multiplier operands for the three partial products of y*y
  always_comb begin
    unique case (state_r)
      ST_SQ1: begin
        mul_a = est_r[31:0];
        mul_b = 32'(est_r[EST_W-1:32]);
      end
      ST_SQ2: begin
        mul_a = 32'(est_r[EST_W-1:32]);
        mul_b = 32'(est_r[EST_W-1:32]);
      end
      default: begin
        mul_a = est_r[31:0];
        mul_b = est_r[31:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Restoring divider step: shift in one dividend bit, try to subtract
  assign div_den   = {1'b0, est_r};
  assign rem_shift = {rem_r[EST_W-1:0], xsh_r[RADICAND_W-1]};
  assign quo_bit   = (rem_shift >= div_den);

  // New estimate, (quotient + estimate) / 2 with saturation
  assign quo_fin  = sat_r ? {QUO_W{1'b1}} : quo_r;
  assign est_sum  = (EST_W+2)'(quo_fin) + (EST_W+2)'(est_r);
  assign est_half = est_sum[EST_W+1:1];

  // Square truncated to Q.32 and the radicand on the same scale
  assign sq_q32    = acc_r[SQ_SHIFT +: 64];
  assign xq        = {12'd0, x_r, 20'd0};
  assign est_wide  = WIDE_W'(est_r);
  assign steps_inc = steps_r + 7'd1;
  assign conv_now  = fits_r && (err_r < 64'(tol_r));

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt  = state_r;
    tol_nxt    = cfg_valid ? cfg_data : tol_r;
    est_nxt    = est_r;
    x_nxt      = x_r;
    steps_nxt  = steps_r;
    xsh_nxt    = xsh_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    sat_nxt    = sat_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    fits_nxt   = fits_r;
    conv_nxt   = conv_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    ovalid_nxt = ovalid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        // Take a request and start its first division
        if (in_tvalid) begin
          x_nxt     = in_tdata[RADICAND_W-1:0];
          xsh_nxt   = in_tdata[RADICAND_W-1:0];
          steps_nxt = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          sat_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; a zero estimate saturates on its own
        xsh_nxt = {xsh_r[RADICAND_W-2:0], 1'b0};
        rem_nxt = quo_bit ? (rem_shift - div_den) : rem_shift;
        if (quo_r[QUO_W-1]) begin
          sat_nxt = 1'b1;
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], quo_bit};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        est_nxt   = est_half[EST_W] ? {EST_W{1'b1}} : est_half[EST_W-1:0];
        state_nxt = ST_SQ0;
      end
      ST_SQ0: begin
        // low half squared
        prod_nxt  = mul_p;
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        // cross term, counted twice
        acc_nxt   = ACC_W'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        // high half squared
        acc_nxt   = acc_r + (ACC_W'(prod_r) << 33);
        prod_nxt  = mul_p;
        state_nxt = ST_SQ3;
      end
      ST_SQ3: begin
        acc_nxt   = acc_r + (ACC_W'(prod_r) << 64);
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        fits_nxt  = (acc_r[ACC_W-1 -: OVF_W] == '0);
        err_nxt   = (sq_q32 > xq) ? (sq_q32 - xq) : (xq - sq_q32);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // Stop on convergence or at the step cap, else run another step
        steps_nxt = steps_inc;
        conv_nxt  = conv_now;
        if (conv_now || (steps_inc == STEPS_W'(MAX_STEPS))) begin
          state_nxt = ST_OUT;
        end else begin
          xsh_nxt   = x_r;
          rem_nxt   = '0;
          quo_nxt   = '0;
          sat_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_OUT: begin
        // Load the output register once the previous result is gone
        if (!ovalid_r || out_tready) begin
          odata_nxt  = {5'd0, steps_r, est_wide[ROOT_W-1:0]};
          ouser_nxt  = conv_r;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and carried-over state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      est_r    <= EST_W'(2) << FRAC_BITS;
      x_r      <= '0;
      steps_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      tol_r    <= tol_nxt;
      est_r    <= est_nxt;
      x_r      <= x_nxt;
      steps_r  <= steps_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Working registers of the divider, multiplier and result
  always_ff @(posedge clk) begin
    xsh_r   <= xsh_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    sat_r   <= sat_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    err_r   <= err_nxt;
    fits_r  <= fits_nxt;
    conv_r  <= conv_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule

// ===== design/nsqrt_chk.sv =====
// ----------------------------------------------------------------------------
// nsqrt_chk
// Port-level checks for the Newton square root block, bound to the top level.
// ----------------------------------------------------------------------------
module nsqrt_chk #(
  parameter int MAX_STEPS = nsqrt_pkg::MAX_STEPS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [nsqrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [nsqrt_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import nsqrt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  // Drop ready after a request: every request runs at least one step
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a request");

  // Report a step count between one and the cap, with zero padding
  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[58:52] != 7'd0) && (out_tdata[58:52] <= 7'(MAX_STEPS))
                   && (out_tdata[63:59] == 5'd0))
    else $error("steps_used out of range");

  // Flag no convergence only when the cap was reached
  a_cap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[58:52] == 7'(MAX_STEPS))
    else $error("not converged before the step cap");

endmodule

bind newton_square_root nsqrt_chk #(.MAX_STEPS(MAX_STEPS)) u_nsqrt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
